// ===== src/waypoint_heading_steer_stall_detect_unit_assert.svh =====
// Assertion macros shared by the waypoint steering checker.
`ifndef WAYPOINT_HEADING_STEER_STALL_DETECT_UNIT_ASSERT_SVH
`define WAYPOINT_HEADING_STEER_STALL_DETECT_UNIT_ASSERT_SVH

// The consequent is checked in the same cycle as the antecedent.
`define WHSSD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define WHSSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/whssd_pkg.sv =====
// Types, constants and the arctangent table of the waypoint steering unit.
`timescale 1ns / 1ps
`default_nettype none
package whssd_pkg;

   localparam int CHECK_PERIOD = 30;
   localparam int STALL_LIMIT  = 5;
   localparam int CORDIC_STEPS = 14;

   localparam int NSTEPS     = (CORDIC_STEPS > 20) ? 20 : CORDIC_STEPS;
   localparam int STEP_W     = $clog2(NSTEPS);
   localparam int PHASE_W    = $clog2(CHECK_PERIOD + 1);
   localparam int STALL_W    = $clog2(STALL_LIMIT + 1);
   localparam int ATAN_IDX_W = 5;
   localparam int Z_W        = 25;
   localparam int CORDIC_W   = 32;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   localparam logic [14:0] TURN_SPEED_RST      = 15'd4096;
   localparam logic [14:0] DRIVE_SPEED_RST     = 15'd4096;
   localparam logic [14:0] REACH_DISTANCE_RST  = 15'd128;
   localparam logic [13:0] ANGLE_THRESHOLD_RST = 14'd410;

   // Angles in Q3.12 and Q20.
   localparam logic signed [16:0]    PI_Q12     = 17'sd12868;
   localparam logic signed [16:0]    TWO_PI_Q12 = 17'sd25736;
   localparam logic signed [Z_W-1:0] PI_Q20     = 25'sd3294199;
   localparam logic signed [14:0]    HEADING_MAX = 15'sd12868;
   localparam logic signed [14:0]    HEADING_MIN = -15'sd12868;

   // Stall check limits.
   localparam logic [16:0] STALL_DRIVE_MIN = 17'd41;
   localparam logic [16:0] STALL_YAW_MIN   = 17'd82;
   localparam logic [16:0] POS_TOL         = 17'd13;
   localparam logic [16:0] HEAD_TOL        = 17'd410;
   localparam logic [16:0] HEAD_WRAP       = 17'd25395;

   // Manual speed requests at or below this magnitude are ignored.
   localparam logic [16:0] MANUAL_MIN = 17'd410;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TURN_SPEED,
      CSR_DRIVE_SPEED,
      CSR_REACH_DISTANCE,
      CSR_ANGLE_THRESHOLD
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POSE,
      ST_SQX,
      ST_SQY,
      ST_SQR,
      ST_ROT,
      ST_DECIDE
   } state_type;

   // Rounded arctangent of 2^-i in units of 2^-20 rad.
   function automatic logic signed [Z_W-1:0] atan_q20(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [Z_W-1:0] val;
      unique case (idx)
         5'd0:    val = 25'sd823550;
         5'd1:    val = 25'sd486170;
         5'd2:    val = 25'sd256879;
         5'd3:    val = 25'sd130396;
         5'd4:    val = 25'sd65451;
         5'd5:    val = 25'sd32757;
         5'd6:    val = 25'sd16383;
         5'd7:    val = 25'sd8192;
         5'd8:    val = 25'sd4096;
         5'd9:    val = 25'sd2048;
         5'd10:   val = 25'sd1024;
         5'd11:   val = 25'sd512;
         5'd12:   val = 25'sd256;
         5'd13:   val = 25'sd128;
         5'd14:   val = 25'sd64;
         5'd15:   val = 25'sd32;
         5'd16:   val = 25'sd16;
         5'd17:   val = 25'sd8;
         5'd18:   val = 25'sd4;
         5'd19:   val = 25'sd2;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

// ===== src/whssd_if.sv =====
// Valid/ready channel interfaces for pose requests and steering responses.
`timescale 1ns / 1ps
`default_nettype none
interface whssd_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y_raw;
   logic signed [15:0] raw_heading;
   logic signed [15:0] goal_x;
   logic signed [15:0] goal_y;
   logic               goal_valid;
   logic               selected;
   logic signed [15:0] manual_drive;
   logic signed [15:0] manual_yaw;
   logic               at_task;

   modport source (
      output valid, pos_x, pos_y_raw, raw_heading, goal_x, goal_y, goal_valid,
             selected, manual_drive, manual_yaw, at_task,
      input  ready
   );
   modport sink (
      input  valid, pos_x, pos_y_raw, raw_heading, goal_x, goal_y, goal_valid,
             selected, manual_drive, manual_yaw, at_task,
      output ready
   );
endinterface

interface whssd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] drive_cmd;
   logic signed [15:0] yaw_cmd;
   logic signed [14:0] heading;
   logic               stalled;
   logic               waypoint_reached;

   modport source (
      output valid, drive_cmd, yaw_cmd, heading, stalled, waypoint_reached,
      input  ready
   );
   modport sink (
      input  valid, drive_cmd, yaw_cmd, heading, stalled, waypoint_reached,
      output ready
   );
endinterface
`default_nettype wire

// ===== src/waypoint_heading_steer_stall_detect_unit.sv =====
// Waypoint steering controller with stall detection, one word per control tick.
//
// A pose word on req_chan carries the measured pose, the pending waypoint and the
// operator speed requests. For each accepted word one response word leaves on
// rsp_chan with the drive and yaw commands, the corrected heading, the stall flag
// and the waypoint-reached flag. The csr_ port writes the four steering registers;
// the user must write them only while the unit is idle; the unit does not enforce this.
// Sequence: after acceptance the word passes POSE, SQX, SQY, SQR and DECIDE when no
// bearing is needed (no waypoint, waypoint reached, or task running), and passes ROT
// between SQR and DECIDE otherwise. The bearing comes from a CORDIC unit that performs one
// micro-rotation per cycle in ROT. A single shared multiplier forms the squared distances
// in SQX, SQY and SQR. req_chan.ready returns in the cycle in which the response is first
// offered, so the unit takes no new pose word before the last one reaches the output register.
// Reset restores the register defaults, clears the stall state and the saved
// commands, and empties the output register.
// The response waits in an output register while the receiver stalls; the unit
// already takes the next pose word and holds it before its final step until the
// output register is free.
`timescale 1ns / 1ps
`default_nettype none
module waypoint_heading_steer_stall_detect_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   whssd_req_if.sink                                 req_chan,
   whssd_rsp_if.source                               rsp_chan,
   input  wire logic                                 csr_wr_en,
   input  wire logic [whssd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [whssd_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   function automatic logic [16:0] mag17(input logic signed [16:0] v);
      return v[16] ? 17'(-v) : 17'(v);
   endfunction

   // Configuration registers.
   logic [14:0] turn_speed_ff;
   logic [14:0] drive_speed_ff;
   logic [14:0] reach_distance_ff;
   logic [13:0] angle_threshold_ff;

   // Sequencer.
   whssd_pkg::state_type state_ff, state_in;
   logic req_ready;
   logic pose_en, sqx_en, sqy_en, sqr_en, rot_en, out_load;

   // Captured request word.
   logic signed [15:0] pos_x_ff, pos_y_raw_ff, raw_heading_ff, goal_x_ff, goal_y_ff;
   logic signed [15:0] manual_drive_ff, manual_yaw_ff;
   logic               goal_valid_ff, selected_ff, at_task_ff;

   // Tick state.
   logic [whssd_pkg::PHASE_W-1:0] tick_phase_ff, tick_phase_in, phase_inc;
   logic [whssd_pkg::STALL_W-1:0] stall_count_ff, stall_count_in;
   logic [whssd_pkg::STALL_W:0]   count_inc;
   logic                          stall_flag_ff, stall_flag_in;
   logic signed [15:0]            last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic signed [14:0]            last_heading_ff, last_heading_in;
   logic signed [15:0]            last_drive_ff, last_yaw_ff;

   // Corrected pose and offsets.
   logic signed [15:0] pos_y;
   logic signed [16:0] rh_wrap, rh_sat, hd;
   logic signed [16:0] dx, dy, dpx, dpy, dhd;

   // Shared multiplier and distance check.
   logic signed [17:0] mul_a, mul_b;
   logic signed [35:0] prod;
   logic [33:0]        d2_ff, d2_in;
   logic               far_ff, far_now;

   // CORDIC unit.
   logic signed [whssd_pkg::CORDIC_W-1:0] cx_ff, cx_in, cy_ff, cy_in, cx0, cy0, xs, ys;
   logic signed [whssd_pkg::Z_W-1:0]      cz_ff, cz_in, atan_val, z_round;
   logic [whssd_pkg::STEP_W-1:0]          step_ff, step_in;

   // Decision.
   logic signed [16:0] bear, delta_s;
   logic [16:0]        delta;
   logic               same_side, turn_right;
   logic signed [15:0] drive_d, yaw_d, man_d, man_y;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] drive_cmd_ff, yaw_cmd_ff;
   logic signed [14:0] heading_ff;
   logic               stalled_ff, reached_ff;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         turn_speed_ff      <= whssd_pkg::TURN_SPEED_RST;
         drive_speed_ff     <= whssd_pkg::DRIVE_SPEED_RST;
         reach_distance_ff  <= whssd_pkg::REACH_DISTANCE_RST;
         angle_threshold_ff <= whssd_pkg::ANGLE_THRESHOLD_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            whssd_pkg::CSR_TURN_SPEED:      turn_speed_ff      <= csr_wr_data;
            whssd_pkg::CSR_DRIVE_SPEED:     drive_speed_ff     <= csr_wr_data;
            whssd_pkg::CSR_REACH_DISTANCE:  reach_distance_ff  <= csr_wr_data;
            whssd_pkg::CSR_ANGLE_THRESHOLD: angle_threshold_ff <= csr_wr_data[13:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         whssd_pkg::ST_IDLE:   if (req_chan.valid) state_in = whssd_pkg::ST_POSE;
         whssd_pkg::ST_POSE:   state_in = whssd_pkg::ST_SQX;
         whssd_pkg::ST_SQX:    state_in = whssd_pkg::ST_SQY;
         whssd_pkg::ST_SQY:    state_in = whssd_pkg::ST_SQR;
         whssd_pkg::ST_SQR: begin
            if (far_now && !at_task_ff) state_in = whssd_pkg::ST_ROT;
            else                        state_in = whssd_pkg::ST_DECIDE;
         end
         whssd_pkg::ST_ROT: begin
            if (step_ff == whssd_pkg::STEP_W'(whssd_pkg::NSTEPS - 1)) begin
               state_in = whssd_pkg::ST_DECIDE;
            end
         end
         whssd_pkg::ST_DECIDE: if (!rsp_valid_ff || rsp_chan.ready) state_in = whssd_pkg::ST_IDLE;
         default:              state_in = whssd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      pose_en   = 1'b0;
      sqx_en    = 1'b0;
      sqy_en    = 1'b0;
      sqr_en    = 1'b0;
      rot_en    = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         whssd_pkg::ST_IDLE:   req_ready = 1'b1;
         whssd_pkg::ST_POSE:   pose_en   = 1'b1;
         whssd_pkg::ST_SQX:    sqx_en    = 1'b1;
         whssd_pkg::ST_SQY:    sqy_en    = 1'b1;
         whssd_pkg::ST_SQR:    sqr_en    = 1'b1;
         whssd_pkg::ST_ROT:    rot_en    = 1'b1;
         whssd_pkg::ST_DECIDE: out_load  = !rsp_valid_ff || rsp_chan.ready;
         default: ;
      endcase
   end

   assign req_chan.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= whssd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_ready) begin
         pos_x_ff        <= req_chan.pos_x;
         pos_y_raw_ff    <= req_chan.pos_y_raw;
         raw_heading_ff  <= req_chan.raw_heading;
         goal_x_ff       <= req_chan.goal_x;
         goal_y_ff       <= req_chan.goal_y;
         goal_valid_ff   <= req_chan.goal_valid;
         selected_ff     <= req_chan.selected;
         manual_drive_ff <= req_chan.manual_drive;
         manual_yaw_ff   <= req_chan.manual_yaw;
         at_task_ff      <= req_chan.at_task;
      end
   end

   // ---------------------------------------------------------------- pose
   always_comb begin
      // Negating the most negative y saturates.
      if (pos_y_raw_ff == 16'sh8000) pos_y = 16'sh7fff;
      else                           pos_y = -pos_y_raw_ff;

      rh_wrap = {raw_heading_ff[15], raw_heading_ff};
      if (rh_wrap > whssd_pkg::PI_Q12) rh_wrap = rh_wrap - whssd_pkg::TWO_PI_Q12;
      rh_sat = (rh_wrap < -whssd_pkg::PI_Q12) ? -whssd_pkg::PI_Q12 : rh_wrap;
      hd     = -rh_sat;

      dx  = {goal_x_ff[15], goal_x_ff} - {pos_x_ff[15], pos_x_ff};
      dy  = {goal_y_ff[15], goal_y_ff} - {pos_y[15], pos_y};
      dpx = {pos_x_ff[15], pos_x_ff} - {last_x_ff[15], last_x_ff};
      dpy = {pos_y[15], pos_y} - {last_y_ff[15], last_y_ff};
      dhd = hd - {{2{last_heading_ff[14]}}, last_heading_ff};
   end

   // Stall check on every CHECK_PERIOD-th tick, against the pose of the last check.
   always_comb begin
      tick_phase_in   = tick_phase_ff;
      stall_count_in  = stall_count_ff;
      stall_flag_in   = stall_flag_ff;
      last_x_in       = last_x_ff;
      last_y_in       = last_y_ff;
      last_heading_in = last_heading_ff;
      phase_inc       = tick_phase_ff + whssd_pkg::PHASE_W'(1);
      count_inc       = {1'b0, stall_count_ff} + (whssd_pkg::STALL_W + 1)'(1);
      if (pose_en) begin
         tick_phase_in = phase_inc;
         if (phase_inc >= whssd_pkg::PHASE_W'(whssd_pkg::CHECK_PERIOD)) begin
            tick_phase_in = '0;
            if (mag17({last_drive_ff[15], last_drive_ff}) < whssd_pkg::STALL_DRIVE_MIN &&
                mag17({last_yaw_ff[15], last_yaw_ff}) < whssd_pkg::STALL_YAW_MIN) begin
               stall_count_in = '0;
               stall_flag_in  = 1'b0;
            end else if (mag17(dpx) < whssd_pkg::POS_TOL && mag17(dpy) < whssd_pkg::POS_TOL &&
                         (mag17(dhd) < whssd_pkg::HEAD_TOL ||
                          mag17(dhd) > whssd_pkg::HEAD_WRAP)) begin
               if (count_inc > (whssd_pkg::STALL_W + 1)'(whssd_pkg::STALL_LIMIT)) begin
                  stall_flag_in  = 1'b1;
                  stall_count_in = whssd_pkg::STALL_W'(whssd_pkg::STALL_LIMIT);
               end else begin
                  stall_count_in = count_inc[whssd_pkg::STALL_W-1:0];
               end
            end
            last_x_in       = pos_x_ff;
            last_y_in       = pos_y;
            last_heading_in = hd[14:0];
         end
      end
   end

   // ---------------------------------------------------------------- distance
   always_comb begin
      if (sqx_en) begin
         mul_a = {dx[16], dx};
         mul_b = {dx[16], dx};
      end else if (sqy_en) begin
         mul_a = {dy[16], dy};
         mul_b = {dy[16], dy};
      end else begin
         mul_a = {3'b000, reach_distance_ff};
         mul_b = {3'b000, reach_distance_ff};
      end
   end

   assign prod    = mul_a * mul_b;
   assign far_now = goal_valid_ff && (d2_ff > prod[33:0]);

   always_comb begin
      d2_in = d2_ff;
      if (sqx_en)      d2_in = prod[33:0];
      else if (sqy_en) d2_in = d2_ff + prod[33:0];
   end

   // ---------------------------------------------------------------- CORDIC
   assign cx0      = {{3{dx[16]}}, dx, 12'b0};
   assign cy0      = {{3{dy[16]}}, dy, 12'b0};
   assign xs       = cx_ff >>> step_ff;
   assign ys       = cy_ff >>> step_ff;
   assign atan_val = whssd_pkg::atan_q20(whssd_pkg::ATAN_IDX_W'(step_ff));

   always_comb begin
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      cz_in   = cz_ff;
      step_in = step_ff;
      if (sqr_en) begin
         step_in = '0;
         // Vectors in the left half plane are mirrored with a base of plus or minus pi.
         if (dx[16]) begin
            cx_in = -cx0;
            cy_in = -cy0;
            cz_in = dy[16] ? -whssd_pkg::PI_Q20 : whssd_pkg::PI_Q20;
         end else begin
            cx_in = cx0;
            cy_in = cy0;
            cz_in = '0;
         end
      end else if (rot_en) begin
         step_in = step_ff + whssd_pkg::STEP_W'(1);
         if (cy_ff > 0) begin
            cx_in = cx_ff + ys;
            cy_in = cy_ff - xs;
            cz_in = cz_ff + atan_val;
         end else if (cy_ff < 0) begin
            cx_in = cx_ff - ys;
            cy_in = cy_ff + xs;
            cz_in = cz_ff - atan_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      d2_ff   <= d2_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      step_ff <= step_in;
      if (sqr_en) far_ff <= far_now;
   end

   // ---------------------------------------------------------------- decision
   always_comb begin
      z_round = (cz_ff + 25'sd128) >>> 8;
      if (z_round > 25'(whssd_pkg::PI_Q12))       bear = whssd_pkg::PI_Q12;
      else if (z_round < -25'(whssd_pkg::PI_Q12)) bear = -whssd_pkg::PI_Q12;
      else                                        bear = z_round[16:0];

      delta_s   = bear - hd;
      delta     = mag17(delta_s);
      same_side = (hd >= 0 && bear >= 0) || (hd <= 0 && bear <= 0);
      if (same_side)   turn_right = bear < hd;
      else if (hd > 0) turn_right = delta < 17'(whssd_pkg::PI_Q12);
      else             turn_right = delta > 17'(whssd_pkg::PI_Q12);

      drive_d = last_drive_ff;
      yaw_d   = last_yaw_ff;
      man_d   = selected_ff ? manual_drive_ff : 16'sd0;
      man_y   = selected_ff ? manual_yaw_ff : 16'sd0;
      if (at_task_ff) begin
         drive_d = '0;
         yaw_d   = '0;
      end else begin
         if (far_ff) begin
            if (delta > {3'b000, angle_threshold_ff}) begin
               drive_d = '0;
               yaw_d   = turn_right ? -$signed({1'b0, turn_speed_ff})
                                    : $signed({1'b0, turn_speed_ff});
            end else begin
               drive_d = $signed({1'b0, drive_speed_ff});
               yaw_d   = '0;
            end
         end
         if (mag17({man_d[15], man_d}) > whssd_pkg::MANUAL_MIN ||
             mag17({man_y[15], man_y}) > whssd_pkg::MANUAL_MIN) begin
            drive_d = man_d;
            yaw_d   = man_y;
         end
      end
   end

   // ---------------------------------------------------------------- state and output
   always_comb begin
      if (out_load)            rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
      else                     rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_phase_ff   <= '0;
         stall_count_ff  <= '0;
         stall_flag_ff   <= 1'b0;
         last_x_ff       <= '0;
         last_y_ff       <= '0;
         last_heading_ff <= '0;
         last_drive_ff   <= '0;
         last_yaw_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         tick_phase_ff   <= tick_phase_in;
         stall_count_ff  <= stall_count_in;
         stall_flag_ff   <= stall_flag_in;
         last_x_ff       <= last_x_in;
         last_y_ff       <= last_y_in;
         last_heading_ff <= last_heading_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (out_load) begin
            last_drive_ff <= drive_d;
            last_yaw_ff   <= yaw_d;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         drive_cmd_ff <= drive_d;
         yaw_cmd_ff   <= yaw_d;
         heading_ff   <= hd[14:0];
         stalled_ff   <= stall_flag_ff;
         reached_ff   <= goal_valid_ff && !far_ff;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.drive_cmd        = drive_cmd_ff;
   assign rsp_chan.yaw_cmd          = yaw_cmd_ff;
   assign rsp_chan.heading          = heading_ff;
   assign rsp_chan.stalled          = stalled_ff;
   assign rsp_chan.waypoint_reached = reached_ff;

endmodule
`default_nettype wire

// ===== src/whssd_checker.sv =====
// Port-level checker for the waypoint steering unit and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "waypoint_heading_steer_stall_detect_unit_assert.svh"
module whssd_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic signed [15:0] rsp_drive_cmd,
   input  wire logic signed [15:0] rsp_yaw_cmd,
   input  wire logic signed [14:0] rsp_heading,
   input  wire logic               rsp_stalled,
   input  wire logic               rsp_waypoint_reached
);

   // One pose word at a time: the unit is busy right after taking one.
   `WHSSD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready stayed high after a pose word was taken")

   // No response can be produced in the cycle after a pose word is taken.
   `WHSSD_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_valid && req_ready, !$rose(rsp_valid), "response appeared too early")

   // The corrected heading always lies within plus or minus pi.
   `WHSSD_ASSERT_SAME(a_heading_range, clock, reset, rsp_valid, (rsp_heading <= whssd_pkg::HEADING_MAX) && (rsp_heading >= whssd_pkg::HEADING_MIN), "heading out of range")

   // A stalled response word holds.
   `WHSSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_drive_cmd) && $stable(rsp_yaw_cmd) && $stable(rsp_heading) && $stable(rsp_stalled) && $stable(rsp_waypoint_reached), "stalled response changed")

endmodule

bind waypoint_heading_steer_stall_detect_unit whssd_checker u_whssd_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_chan.valid),
   .req_ready            (req_chan.ready),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .rsp_drive_cmd        (rsp_chan.drive_cmd),
   .rsp_yaw_cmd          (rsp_chan.yaw_cmd),
   .rsp_heading          (rsp_chan.heading),
   .rsp_stalled          (rsp_chan.stalled),
   .rsp_waypoint_reached (rsp_chan.waypoint_reached)
);
`default_nettype wire
